@@ design/stws_pkg.sv @@
`default_nettype none

package stws_pkg;

  // Default number of leaves in the tree.
  localparam int unsigned LEAVES_DEFAULT = 1024;

  // Fixed field widths of the item channels.
  localparam int unsigned LEAF_W   = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned TOTAL_W  = 42;

  // Action codes carried by an input item.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic w_start;
    logic w_up;
    logic s_mul;
    logic s_tgt;
    logic s_down;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic new_sample;
    logic idx_ok;
    logic up_at_root;
    logic down_at_leaf;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ design/stws_in_if.sv @@
`default_nettype none

interface stws_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [stws_pkg::LEAF_W-1:0]   leaf_index;
  logic [stws_pkg::WEIGHT_W-1:0] leaf_weight;
  logic [stws_pkg::FRAC_W-1:0]   random_fraction;

  modport source (
    output valid, action, leaf_index, leaf_weight, random_fraction,
    input  ready
  );

  modport sink (
    input  valid, action, leaf_index, leaf_weight, random_fraction,
    output ready
  );
endinterface

`default_nettype wire

@@ design/stws_out_if.sv @@
`default_nettype none

interface stws_out_if;
  logic                         valid;
  logic                         ready;
  logic [stws_pkg::LEAF_W-1:0]  sampled_leaf;
  logic [stws_pkg::TOTAL_W-1:0] total_weight;
  logic                         was_sample;

  modport source (
    output valid, sampled_leaf, total_weight, was_sample,
    input  ready
  );

  modport sink (
    input  valid, sampled_leaf, total_weight, was_sample,
    output ready
  );
endinterface

`default_nettype wire

@@ design/stws_ctrl.sv @@
`default_nettype none

module stws_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire stws_pkg::ctrl_sts_t sts,
  output stws_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_W_START = 8'b0000_0100,
    ST_W_UP    = 8'b0000_1000,
    ST_S_MUL   = 8'b0001_0000,
    ST_S_TGT   = 8'b0010_0000,
    ST_S_DOWN  = 8'b0100_0000,
    ST_FINISH  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the node memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.new_sample ? ST_S_MUL : ST_W_START;
        end
      end
      ST_W_START: begin
        cmd.w_start = 1'b1;
        state_next  = sts.idx_ok ? ST_W_UP : ST_FINISH;
      end
      ST_W_UP: begin
        cmd.w_up = 1'b1;
        if (sts.up_at_root) begin
          state_next = ST_FINISH;
        end
      end
      ST_S_MUL: begin
        cmd.s_mul  = 1'b1;
        state_next = ST_S_TGT;
      end
      ST_S_TGT: begin
        cmd.s_tgt  = 1'b1;
        state_next = ST_S_DOWN;
      end
      ST_S_DOWN: begin
        cmd.s_down = 1'b1;
        if (sts.down_at_leaf) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/stws_datapath.sv @@
`default_nettype none

module stws_datapath #(
  parameter int unsigned LEAVES = stws_pkg::LEAVES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stws_pkg::ctrl_cmd_t           cmd,
  output stws_pkg::ctrl_sts_t                sts,
  input  wire logic                          in_action,
  input  wire logic [stws_pkg::LEAF_W-1:0]   in_leaf_index,
  input  wire logic [stws_pkg::WEIGHT_W-1:0] in_leaf_weight,
  input  wire logic [stws_pkg::FRAC_W-1:0]   in_random_fraction,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [stws_pkg::LEAF_W-1:0]        out_sampled_leaf,
  output logic [stws_pkg::TOTAL_W-1:0]       out_total_weight,
  output logic                               out_was_sample
);

  localparam int unsigned LEAF_AW = $clog2(LEAVES);
  localparam int unsigned NODE_AW = LEAF_AW + 1;
  localparam int unsigned DEPTH   = 2 * LEAVES;
  localparam int unsigned NODE_W  = stws_pkg::WEIGHT_W + LEAF_AW;
  localparam int unsigned FRAC1_W = stws_pkg::FRAC_W + 1;
  localparam int unsigned PLO_W   = FRAC1_W + stws_pkg::WEIGHT_W;
  localparam int unsigned PHI_W   = FRAC1_W + LEAF_AW;
  localparam int unsigned TGT_W   = NODE_W + 2;

  // Node sum memory: node 1 is the root, node v has children 2v and 2v+1.
  logic [NODE_W-1:0] mem [DEPTH];
  logic [NODE_W-1:0] rdata;
  logic [NODE_AW-1:0] raddr;
  logic [NODE_AW-1:0] waddr;
  logic [NODE_W-1:0]  wdata;
  logic               we;

  // Item and walk registers.
  logic [NODE_AW-1:0]              clr_addr;
  logic [NODE_AW-1:0]              node;
  logic [NODE_W-1:0]               acc;
  logic [NODE_W-1:0]               target;
  logic [NODE_W-1:0]               root_sum;
  logic                            cap_action;
  logic [stws_pkg::LEAF_W-1:0]     cap_idx;
  logic [stws_pkg::WEIGHT_W-1:0]   cap_weight;
  logic [stws_pkg::FRAC_W-1:0]     cap_r;
  logic [PLO_W-1:0]                prod_lo;
  logic [PHI_W-1:0]                prod_hi;

  // Derived values.
  logic [NODE_AW-1:0] leaf_node;
  logic [NODE_AW-1:0] parent;
  logic [NODE_W-1:0]  up_sum;
  logic [NODE_AW-1:0] child;
  logic               go_right;
  logic [NODE_AW-1:0] next_node;
  logic [NODE_AW-1:0] next_child;
  logic [FRAC1_W-1:0] frac;
  logic [PLO_W:0]     lo_round;
  logic [TGT_W-1:0]   tgt_sum;
  logic               idx_ok;

  // Address arithmetic for the upward refresh and the downward walk.
  always_comb begin
    leaf_node  = NODE_AW'(LEAVES) + NODE_AW'(cap_idx);
    parent     = node >> 1;
    up_sum     = acc + rdata;
    child      = {node[NODE_AW-2:0], 1'b0};
    go_right   = rdata < target;
    next_node  = child | NODE_AW'(go_right);
    next_child = {next_node[NODE_AW-2:0], 1'b0};
    idx_ok     = 32'(cap_idx) < 32'(LEAVES);
  end

  // Fixed-point target: ceil((r + 1) * total / 2^32), from two partial products.
  always_comb begin
    frac     = FRAC1_W'(cap_r) + FRAC1_W'(1);
    lo_round = {1'b0, prod_lo} + (PLO_W + 1)'({stws_pkg::WEIGHT_W{1'b1}});
    tgt_sum  = TGT_W'(prod_hi) + TGT_W'(lo_round[PLO_W:stws_pkg::WEIGHT_W]);
  end

  // Memory read address: sibling on the way up, child on the way down.
  always_comb begin
    raddr = '0;
    if (cmd.w_start) begin
      raddr = leaf_node ^ NODE_AW'(1);
    end else if (cmd.w_up) begin
      raddr = parent ^ NODE_AW'(1);
    end else if (cmd.s_tgt) begin
      raddr = NODE_AW'(2);
    end else if (cmd.s_down) begin
      raddr = next_child;
    end
  end

  // Memory write port: clearing pass, leaf store, ancestor refresh.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (cmd.w_start && idx_ok) begin
      we    = 1'b1;
      waddr = leaf_node;
      wdata = NODE_W'(cap_weight);
    end else if (cmd.w_up) begin
      we    = 1'b1;
      waddr = parent;
      wdata = up_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control registers: clearing address, root copy and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      root_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + NODE_AW'(1);
      end
      if (cmd.w_up && (parent == NODE_AW'(1))) begin
        root_sum <= up_sum;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the item in flight and of the result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_action <= in_action;
      cap_idx    <= in_leaf_index;
      cap_weight <= in_leaf_weight;
      cap_r      <= in_random_fraction;
    end
    if (cmd.w_start) begin
      node <= leaf_node;
      acc  <= NODE_W'(cap_weight);
    end else if (cmd.w_up) begin
      node <= parent;
      acc  <= up_sum;
    end else if (cmd.s_tgt) begin
      node <= NODE_AW'(1);
    end else if (cmd.s_down) begin
      node <= next_node;
    end
    if (cmd.s_mul) begin
      prod_lo <= PLO_W'(frac) * PLO_W'(root_sum[stws_pkg::WEIGHT_W-1:0]);
      prod_hi <= PHI_W'(frac) * PHI_W'(root_sum[NODE_W-1:stws_pkg::WEIGHT_W]);
    end
    if (cmd.s_tgt) begin
      target <= tgt_sum[NODE_W-1:0];
    end else if (cmd.s_down && go_right) begin
      target <= target - rdata;
    end
    if (cmd.finish) begin
      out_sampled_leaf <= (cap_action == stws_pkg::ACT_SAMPLE)
                          ? stws_pkg::LEAF_W'(node - NODE_AW'(LEAVES)) : '0;
      out_total_weight <= stws_pkg::TOTAL_W'(root_sum);
      out_was_sample   <= cap_action;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clear_last   = clr_addr == NODE_AW'(DEPTH - 1);
    sts.new_sample   = in_action == stws_pkg::ACT_SAMPLE;
    sts.idx_ok       = idx_ok;
    sts.up_at_root   = parent == NODE_AW'(1);
    sts.down_at_leaf = 32'(next_node) >= 32'(LEAVES);
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

@@ design/sum_tree_weighted_sampler_unit.sv @@
// Weighted sampler over an implicit binary sum tree of LEAVES leaves.
// Items arrive on in_item (valid/ready). action 0 writes leaf_weight to leaf
// leaf_index and refreshes every ancestor sum; action 1 scales
// random_fraction by the root total and walks down to the chosen leaf.
// Every item yields one result on out_item: the sampled leaf (zero for
// writes), the root total after the item and a flag for sample results.
// A write to a leaf index outside the tree changes nothing and reports the
// current total.
// The node memory has a single read and write port and serves one tree level
// per cycle. One item is in work at a time; the next one is taken in the
// cycle after its result is loaded.
// After reset the block clears all 2 * LEAVES entries of the node memory, one
// node per cycle, with in_item.ready low.
// The result sits in an output register; if the receiver stalls, the
// following item still runs and waits for that register to free up.
`default_nettype none

module sum_tree_weighted_sampler_unit #(
  parameter int unsigned LEAVES = stws_pkg::LEAVES_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  stws_in_if.sink      in_item,
  stws_out_if.source   out_item
);

  stws_pkg::ctrl_cmd_t cmd;
  stws_pkg::ctrl_sts_t sts;
  logic                in_ready;
  logic                out_valid;
  logic [stws_pkg::LEAF_W-1:0]  sampled_leaf;
  logic [stws_pkg::TOTAL_W-1:0] total_weight;
  logic                         was_sample;

  // Sequencer for the clearing pass, the upward refresh and the descent.
  stws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Node memory, arithmetic and result register.
  stws_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_item.action),
    .in_leaf_index      (in_item.leaf_index),
    .in_leaf_weight     (in_item.leaf_weight),
    .in_random_fraction (in_item.random_fraction),
    .out_valid          (out_valid),
    .out_ready          (out_item.ready),
    .out_sampled_leaf   (sampled_leaf),
    .out_total_weight   (total_weight),
    .out_was_sample     (was_sample)
  );

  // Channel hookup.
  assign in_item.ready         = in_ready;
  assign out_item.valid        = out_valid;
  assign out_item.sampled_leaf = sampled_leaf;
  assign out_item.total_weight = total_weight;
  assign out_item.was_sample   = was_sample;

endmodule

`default_nettype wire

@@ tb/stws_tree_monitor.sv @@
`default_nettype none

module stws_tree_monitor #(
  parameter int unsigned LEAVES = stws_pkg::LEAVES_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  stws_in_if          in_ch,
  stws_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [stws_pkg::LEAF_W-1:0]  leaf;
    logic [stws_pkg::TOTAL_W-1:0] total;
    logic                         was_sample;
  } tree_result_t;

  // Shadow copy of the sum tree: node 1 is the root, leaf i sits at node LEAVES + i.
  logic [63:0] tree_sums [2*LEAVES];

  // Results still owed by the block, oldest first.
  tree_result_t pending_tree_results [$];

  int unsigned error_total;

  // Applies one item to the shadow tree and returns the result it should produce.
  function automatic tree_result_t tree_apply_item(
    input logic                          act,
    input logic [stws_pkg::LEAF_W-1:0]   idx,
    input logic [stws_pkg::WEIGHT_W-1:0] weight,
    input logic [stws_pkg::FRAC_W-1:0]   frac_raw
  );
    longint unsigned node;
    longint unsigned frac;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned target;
    tree_result_t    res;

    res.leaf = '0;
    if (act == stws_pkg::ACT_WRITE) begin
      // A write refreshes every ancestor on the way to the root.
      if (idx < LEAVES) begin
        node = LEAVES + idx;
        tree_sums[node] = {32'd0, weight};
        node = node >> 1;
        while (node >= 1) begin
          tree_sums[node] = tree_sums[2*node] + tree_sums[2*node+1];
          node = node >> 1;
        end
      end
    end else begin
      // The target is ceil((r + 1) * T / 2^32), split so that no product overflows.
      frac   = {32'd0, frac_raw} + 64'd1;
      hi     = tree_sums[1] >> 32;
      lo     = tree_sums[1] & 64'hFFFF_FFFF;
      target = frac * hi + ((frac * lo + 64'hFFFF_FFFF) >> 32);
      node   = 1;
      while (node < LEAVES) begin
        node = 2 * node;
        if (tree_sums[node] < target) begin
          target = target - tree_sums[node];
          node   = node + 1;
        end
      end
      res.leaf = stws_pkg::LEAF_W'(node - LEAVES);
    end
    res.total      = tree_sums[1][stws_pkg::TOTAL_W-1:0];
    res.was_sample = act;
    return res;
  endfunction

  // Compare each accepted result first, then record the item accepted at the same edge.
  always @(posedge clk) begin : watch
    tree_result_t want;

    if (rst) begin
      foreach (tree_sums[n]) tree_sums[n] = '0;
      pending_tree_results.delete();
      error_total = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_tree_results.size() == 0) begin
          $display("%0t: result with none expected: leaf %0d total %0h draw %0b", $time,
                   out_ch.sampled_leaf, out_ch.total_weight, out_ch.was_sample);
          error_total++;
        end else begin
          want = pending_tree_results.pop_front();
          if (out_ch.sampled_leaf !== want.leaf) begin
            $display("%0t: sampled_leaf expected %0d got %0d", $time, want.leaf,
                     out_ch.sampled_leaf);
            error_total++;
          end
          if (out_ch.total_weight !== want.total) begin
            $display("%0t: total_weight expected %0h got %0h", $time, want.total,
                     out_ch.total_weight);
            error_total++;
          end
          if (out_ch.was_sample !== want.was_sample) begin
            $display("%0t: was_sample expected %0b got %0b", $time, want.was_sample,
                     out_ch.was_sample);
            error_total++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        pending_tree_results.push_back(tree_apply_item(in_ch.action, in_ch.leaf_index,
                                                       in_ch.leaf_weight,
                                                       in_ch.random_fraction));
      end
    end
    mismatch_count <= error_total;
    outstanding    <= pending_tree_results.size();
  end

endmodule

`default_nettype wire

@@ tb/sum_tree_weighted_sampler_unit_tb.sv @@
`default_nettype none

module sum_tree_weighted_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES    = 40;

  typedef enum int unsigned {RX_OPEN, RX_HALF, RX_SPARSE, RX_CADENCE} rx_mode_t;
  typedef enum int unsigned {W_MIXED, W_HEAVY, W_SPARSE} weight_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned                 cycle_count = 0;
  int unsigned                 mismatch_count;
  int unsigned                 outstanding;
  int unsigned                 burst_left = 0;
  int unsigned                 hold_req = 0;
  logic [stws_pkg::LEAF_W-1:0] sweep_leaf = '0;

  stws_in_if  in_ch ();
  stws_out_if out_ch ();

  sum_tree_weighted_sampler_unit #(.LEAVES(stws_pkg::LEAVES_DEFAULT)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  stws_tree_monitor #(.LEAVES(stws_pkg::LEAVES_DEFAULT)) tree_monitor (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sum_tree_weighted_sampler_unit_tb: FAIL");
      $finish;
    end
  end

  // Receiver: stalls follow a mode that changes now and then, plus long holds on request.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_served;
    int unsigned beat;

    mode        = RX_OPEN;
    mode_left   = 0;
    hold_left   = 0;
    hold_served = 0;
    beat        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left   = LONG_HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (mode)
          RX_OPEN:    out_ch.ready <= 1'b1;
          RX_HALF:    out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    out_ch.ready <= (beat % 3 != 0);
        endcase
      end
    end
  end

  // Weight shapes: mixed magnitudes, mostly near full scale, or mostly empty leaves.
  function automatic logic [stws_pkg::WEIGHT_W-1:0] pick_weight(input weight_style_t style);
    int unsigned roll;

    roll = $urandom_range(0, 19);
    if (style == W_HEAVY)
      return (roll < 4) ? '1 : ($urandom | 32'hF000_0000);
    if (style == W_SPARSE && roll < 17)
      return '0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(1, 255);
      4:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and returns at the edge where it is taken. Bursts end in a gap.
  task automatic send_item(
    input logic                          act,
    input logic [stws_pkg::LEAF_W-1:0]   idx,
    input logic [stws_pkg::WEIGHT_W-1:0] weight,
    input logic [stws_pkg::FRAC_W-1:0]   frac
  );
    int unsigned gap;

    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_ch.valid           <= 1'b1;
    in_ch.action          <= act;
    in_ch.leaf_index      <= idx;
    in_ch.leaf_weight     <= weight;
    in_ch.random_fraction <= frac;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random stretch of items; the mixed stretch also triggers the long receiver hold.
  task automatic run_phase(
    input int unsigned   count,
    input int unsigned   draw_pct,
    input weight_style_t style
  );
    int unsigned                 k;
    logic                        act;
    logic [stws_pkg::LEAF_W-1:0] idx;
    logic [stws_pkg::FRAC_W-1:0] frac;

    for (k = 0; k < count; k++) begin
      if (style == W_MIXED && k == 200) begin
        hold_req   <= hold_req + 1;
        burst_left = 80;
      end
      act = ($urandom_range(1, 100) <= draw_pct) ? stws_pkg::ACT_SAMPLE : stws_pkg::ACT_WRITE;
      if (style == W_HEAVY && $urandom_range(0, 3) != 0) begin
        idx        = sweep_leaf;
        sweep_leaf = sweep_leaf + 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        idx = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        idx = stws_pkg::LEAF_W'($urandom);
      end
      case ($urandom_range(0, 9))
        0:       frac = '0;
        1:       frac = '1;
        default: frac = $urandom;
      endcase
      send_item(act, idx, pick_weight(style), frac);
    end
    drain_results();
  endtask

  // Stimulus and verdict.
  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.action          <= stws_pkg::ACT_WRITE;
    in_ch.leaf_index      <= '0;
    in_ch.leaf_weight     <= '0;
    in_ch.random_fraction <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Draws from an empty tree come back as leaf zero with a zero total.
    send_item(stws_pkg::ACT_SAMPLE, '0, $urandom, '0);
    send_item(stws_pkg::ACT_SAMPLE, '1, '1, '1);

    // A single full-scale leaf at each end of the tree.
    send_item(stws_pkg::ACT_WRITE, '0, '1, $urandom);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, '0);
    send_item(stws_pkg::ACT_SAMPLE, '1, '1, '1);
    send_item(stws_pkg::ACT_WRITE, '1, '1, '0);
    send_item(stws_pkg::ACT_SAMPLE, stws_pkg::LEAF_W'($urandom), $urandom, '0);
    send_item(stws_pkg::ACT_SAMPLE, stws_pkg::LEAF_W'($urandom), $urandom, 32'h7FFF_FFFF);
    send_item(stws_pkg::ACT_SAMPLE, stws_pkg::LEAF_W'($urandom), $urandom, 32'h8000_0000);
    send_item(stws_pkg::ACT_SAMPLE, stws_pkg::LEAF_W'($urandom), $urandom, '1);

    // Zero-weight leaves must be skipped by the descent.
    send_item(stws_pkg::ACT_WRITE, '0, '0, $urandom);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, '0);
    send_item(stws_pkg::ACT_SAMPLE, '1, '1, '1);

    // Two unit weights in the middle: the split falls exactly on the halfway fraction.
    send_item(stws_pkg::ACT_WRITE, 10'd512, 32'd1, '0);
    send_item(stws_pkg::ACT_WRITE, 10'd511, 32'd1, '1);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, '0);
    send_item(stws_pkg::ACT_WRITE, '1, '0, $urandom);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, 32'h7FFF_FFFF);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, 32'h8000_0000);
    send_item(stws_pkg::ACT_SAMPLE, '0, '0, '1);

    // Alternating bit patterns in index and weight.
    send_item(stws_pkg::ACT_WRITE, 10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(stws_pkg::ACT_WRITE, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(stws_pkg::ACT_SAMPLE, 10'h155, 32'hAAAA_AAAA, $urandom);
    drain_results();

    // Random stretches: mixed, then a fill toward a large total, then a sparse tree.
    run_phase(700, 50, W_MIXED);
    run_phase(500, 20, W_HEAVY);
    run_phase(650, 50, W_SPARSE);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("sum_tree_weighted_sampler_unit_tb: PASS");
    else
      $display("sum_tree_weighted_sampler_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/stws_pkg.sv
design/stws_in_if.sv
design/stws_out_if.sv
design/stws_ctrl.sv
design/stws_datapath.sv
design/sum_tree_weighted_sampler_unit.sv
tb/stws_tree_monitor.sv
tb/sum_tree_weighted_sampler_unit_tb.sv
